@@ sv/kte_pkg.sv @@
// Shared types and constants for the keyed table engine.
// No dependencies; imported by the datapath, the controller and the top of the block.
`default_nettype none

package kte_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int CAP_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int OPC_W     = 2;
    localparam int STAT_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OPC_W-1:0] {
        OP_FIND = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_item;
        logic    capture_hits;
        logic    set_result;
        status_t status_code;
        logic    keep_slot;
        logic    append;
        logic    move_key;
        logic    read_last;
        logic    read_pos;
        logic    store_found;
        logic    move_write;
        logic    dec_count;
        logic    load_out;
    } kte_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             any_hit;
        logic             full;
        logic             empty;
        logic             pos_is_last;
    } kte_flags_t;

endpackage

`default_nettype wire

@@ sv/kte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the data store of the keyed table engine.
`default_nettype none

module kte_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/kte_dp.sv @@
// Datapath of the keyed table engine: key store, parallel key compare,
// entry count, capacity register, result and output registers.
// Depends on kte_pkg and kte_ram.
`default_nettype none

module kte_dp
    import kte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire kte_cmd_t                 cmd,
    output kte_flags_t                    flags,
    input  wire logic [OPC_W-1:0]         opcode,
    input  wire logic signed [KEY_W-1:0]  key,
    input  wire logic signed [KEY_W-1:0]  data,
    input  wire logic                     cfg_we,
    input  wire logic [CAP_W-1:0]         cfg_capacity,
    output logic [STAT_W-1:0]             status,
    output logic [SLOT_W-1:0]             slot,
    output logic signed [KEY_W-1:0]       found_data,
    output logic [CNT_W-1:0]              entry_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [OPC_W-1:0]        op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        data_reg;
    logic [KEY_W-1:0]        key_store [DEPTH];
    logic [DEPTH-1:0]        hit_reg;
    logic [DEPTH-1:0]        hit_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CAP_W-1:0]        capacity_reg;
    logic [STAT_W-1:0]       res_status_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [KEY_W-1:0]        res_data_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [KEY_W-1:0]        found_data_reg;
    logic [CNT_W-1:0]        entry_count_reg;

    logic [IW-1:0]           pos;
    logic [CW-1:0]           last;
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [IW-1:0]           ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;

    assign last = count_reg - CW'(1);

    // Keys are unique among filled slots, so OR-ing the indexes encodes the hit
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_reg[i])
            begin
                pos = pos | IW'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (key_store[i] == key_reg) && (CW'(i) < count_reg);
        end
    end

    assign flags.op          = op_reg;
    assign flags.any_hit     = |hit_reg;
    assign flags.full        = (count_reg == CW'(DEPTH)) ||
                               (EW'(count_reg) >= EW'(capacity_reg));
    assign flags.empty       = (count_reg == '0);
    assign flags.pos_is_last = (CW'(pos) == last);

    // Data store port selection
    assign ram_we    = cmd.append | cmd.move_write;
    assign ram_waddr = cmd.append ? count_reg[IW-1:0] : pos;
    assign ram_wdata = cmd.append ? data_reg : ram_rdata;
    assign ram_re    = cmd.read_last | cmd.read_pos;
    assign ram_raddr = cmd.read_last ? last[IW-1:0] : pos;

    kte_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= opcode;
            key_reg  <= key;
            data_reg <= data;
        end
        if (cmd.capture_hits)
        begin
            hit_reg <= hit_next;
        end
        if (cmd.append)
        begin
            key_store[count_reg[IW-1:0]] <= key_reg;
        end
        else if (cmd.move_key)
        begin
            key_store[pos] <= key_store[last[IW-1:0]];
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.status_code;
            res_slot_reg   <= cmd.keep_slot ? SLOT_W'(pos) : '0;
            res_data_reg   <= '0;
        end
        else if (cmd.store_found)
        begin
            res_data_reg <= ram_rdata;
        end
        if (cmd.load_out)
        begin
            status_reg      <= res_status_reg;
            slot_reg        <= res_slot_reg;
            found_data_reg  <= res_data_reg;
            entry_count_reg <= CNT_W'(count_reg);
        end
    end

    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_data  = found_data_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture_hits |=> $onehot0(hit_reg))
        else $error("key matched in more than one slot");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not advance entry count");

endmodule

`default_nettype wire

@@ sv/kte_ctrl.sv @@
// Controller of the keyed table engine: sequences compare, decision,
// data store access and result transfer for one operation at a time.
// Depends on kte_pkg.
`default_nettype none

module kte_ctrl
    import kte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire kte_flags_t flags,
    output kte_cmd_t        cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_DEC  = 6'b000100,
        S_READ = 6'b001000,
        S_MOVE = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.capture_hits = 1'b1;
                state_next       = S_DEC;
            end
            S_DEC:
            begin
                cmd.set_result  = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_DONE;
                unique case (flags.op)
                    OP_ADD:
                    begin
                        priority if (flags.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else if (flags.any_hit)
                        begin
                            cmd.status_code = ST_EXISTS;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    OP_DEL:
                    begin
                        priority if (flags.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                        end
                        else if (!flags.any_hit)
                        begin
                            cmd.status_code = ST_NOTFOUND;
                        end
                        else if (flags.pos_is_last)
                        begin
                            cmd.dec_count = 1'b1;
                        end
                        else
                        begin
                            // copy the last key now, fetch its data for the next cycle
                            cmd.move_key  = 1'b1;
                            cmd.read_last = 1'b1;
                            state_next    = S_MOVE;
                        end
                    end
                    default:
                    begin
                        // find, and the unused code acting as find
                        if (flags.any_hit)
                        begin
                            cmd.keep_slot = 1'b1;
                            cmd.read_pos  = 1'b1;
                            state_next    = S_READ;
                        end
                        else
                        begin
                            cmd.status_code = ST_NOTFOUND;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                cmd.store_found = 1'b1;
                state_next      = S_DONE;
            end
            S_MOVE:
            begin
                cmd.move_write = 1'b1;
                cmd.dec_count  = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.load_out)
        else $error("result loaded over a stalled result");

    a_move_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_write |-> $past(cmd.read_last))
        else $error("slot move without a prior data read");

    a_found_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_found |-> $past(cmd.read_pos))
        else $error("found data captured without a prior read");

endmodule

`default_nettype wire

@@ sv/keyed_table_engine_core.sv @@
// Keyed table engine: find / add / delete on an unordered table of keys.
// Each operation steps through compare, decide and done states; a successful find
// or a delete that moves the last entry also passes a read or move state (data store read).
// A new item is taken only once the controller is back in idle, after the previous
// result has been loaded into the output registers, which can wait on out_stall.
// Reset: entry count cleared, capacity set to 16; stores are not cleared.
`default_nettype none

module keyed_table_engine_core
    import kte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OPC_W-1:0]         opcode,
    input  wire logic signed [KEY_W-1:0]  key,
    input  wire logic signed [KEY_W-1:0]  data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STAT_W-1:0]             status,
    output logic [SLOT_W-1:0]             slot,
    output logic signed [KEY_W-1:0]       found_data,
    output logic [CNT_W-1:0]              entry_count,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CAP_W-1:0]         capacity
);

    kte_cmd_t   cmd;
    kte_flags_t flags;

    assign cfg_ready = 1'b1;

    kte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    kte_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .flags        (flags),
        .opcode       (opcode),
        .key          (key),
        .data         (data),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_capacity (capacity),
        .status       (status),
        .slot         (slot),
        .found_data   (found_data),
        .entry_count  (entry_count)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for keyed_table_engine_core: find / add / delete traffic
// with bursty input, patterned output stalls and capacity changes between phases.
// Depends on kte_pkg and the keyed_table_engine_core RTL only.
`timescale 1ns / 100ps

module tb;
    import kte_pkg::*;

    localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
    localparam int POOL_N       = 24;
    localparam int PHASE_ITEMS  = 150;
    localparam int N_PHASES     = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_DIR        = 20;

    typedef struct packed {
        status_t             st;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    fdata;
        logic [CNT_W-1:0]    cnt;
    } table_result_t;

    typedef struct packed {
        logic [OPC_W-1:0]    op;
        logic [KEY_W-1:0]    k;
        logic [KEY_W-1:0]    d;
        logic                typed;
        table_result_t       res;
    } dir_row_t;

    // Directed sequence on capacity 16; untyped rows go through the table model
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{OP_FIND,  32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_NOTFOUND, 4'd0, 32'h0, 5'd0}},
        '{OP_DEL,   32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_EMPTY,    4'd0, 32'h0, 5'd0}},
        '{OP_SPARE, 32'h0000_0005, 32'hA5A5_A5A5, 1'b1, '{ST_NOTFOUND, 4'd0, 32'h0, 5'd0}},
        '{OP_ADD,   32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd1}},
        '{OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd2}},
        '{OP_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd3}},
        '{OP_ADD,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd4}},
        '{OP_ADD,   32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{ST_EXISTS,   4'd0, 32'h0, 5'd4}},
        '{OP_FIND,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_OK, 4'd1, 32'h8000_0000, 5'd4}},
        '{OP_FIND,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_OK, 4'd2, 32'hFFFF_FFFF, 5'd4}},
        '{OP_SPARE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       4'd3, 32'h0, 5'd4}},
        '{OP_FIND,  32'h7FFF_FFFE, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 4'd0, 32'h0, 5'd4}},
        '{OP_DEL,   32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd3}},
        '{OP_FIND,  32'h0000_0000, 32'h1234_5678, 1'b0, '{ST_OK,       4'd0, 32'h0, 5'd0}},
        '{OP_DEL,   32'h0000_3039, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 4'd0, 32'h0, 5'd3}},
        '{OP_DEL,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd2}},
        '{OP_FIND,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{ST_OK,       4'd0, 32'h0, 5'd0}},
        '{OP_DEL,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{ST_OK,       4'd0, 32'h0, 5'd0}},
        '{OP_DEL,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK,       4'd0, 32'h0, 5'd0}},
        '{OP_FIND,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 4'd0, 32'h0, 5'd0}}
    };

    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{
        5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd16, 5'd2, 5'd12
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [OPC_W-1:0]          opcode = '0;
    logic signed [KEY_W-1:0]   key = '0;
    logic signed [KEY_W-1:0]   data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STAT_W-1:0]         status;
    logic [SLOT_W-1:0]         slot;
    logic signed [KEY_W-1:0]   found_data;
    logic [CNT_W-1:0]          entry_count;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_capacity = CAP_RESET;

    // Table model state
    logic [KEY_W-1:0]          table_keys [DEPTH_DEF];
    logic [KEY_W-1:0]          table_data [DEPTH_DEF];
    int                        table_count = 0;
    logic [CAP_W-1:0]          table_cap = CAP_RESET;

    table_result_t             pending_results [$];
    logic [KEY_W-1:0]          key_pool [POOL_N];
    int                        errors = 0;
    int                        burst_left = 0;
    bit                        no_gaps = 1'b0;
    int                        hold_requests = 0;
    int                        holds_served = 0;
    int                        hold_left = 0;
    int                        stall_mode = 0;
    int                        mode_left = 0;
    int                        stall_phase = 0;

    keyed_table_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .key         (key),
        .data        (data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .found_data  (found_data),
        .entry_count (entry_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (cfg_capacity)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic table_result_t apply_table_op(input logic [OPC_W-1:0] op,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [KEY_W-1:0] d);
        table_result_t r;
        int            pos;
        int            eff_cap;
        int            i;
        r.st    = ST_OK;
        r.slot  = '0;
        r.fdata = '0;
        pos     = -1;
        for (i = 0; i < table_count; i++)
        begin
            if (pos < 0 && table_keys[i] == k)
                pos = i;
        end
        eff_cap = (table_cap < DEPTH_DEF) ? int'(table_cap) : DEPTH_DEF;
        case (op)
            OP_ADD:
            begin
                if (table_count >= eff_cap)
                    r.st = ST_FULL;
                else if (pos >= 0)
                    r.st = ST_EXISTS;
                else
                begin
                    table_keys[table_count] = k;
                    table_data[table_count] = d;
                    table_count++;
                end
            end
            OP_DEL:
            begin
                if (table_count == 0)
                    r.st = ST_EMPTY;
                else if (pos < 0)
                    r.st = ST_NOTFOUND;
                else
                begin
                    // move the last entry into the freed slot
                    table_keys[pos] = table_keys[table_count-1];
                    table_data[pos] = table_data[table_count-1];
                    table_count--;
                end
            end
            default:
            begin
                if (pos >= 0)
                begin
                    r.slot  = pos[SLOT_W-1:0];
                    r.fdata = table_data[pos];
                end
                else
                    r.st = ST_NOTFOUND;
            end
        endcase
        r.cnt = table_count[CNT_W-1:0];
        return r;
    endfunction

    // Offer one item in bursts with random gaps; predict at the transfer
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [KEY_W-1:0] d, input logic typed,
                             input table_result_t typed_res);
        int            gap;
        table_result_t predicted;
        if (burst_left == 0 && !no_gaps)
        begin
            gap = $urandom_range(0, 7);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        data     <= d;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_table_op(op, k, d);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Write capacity only once the engine has drained
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        cfg_capacity <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        table_cap = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d count %0d",
                       status, entry_count);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    errors++;
                end
                if (found_data !== want.fdata)
                begin
                    $error("found_data: expected %h, got %h", want.fdata, found_data);
                    errors++;
                end
                if (entry_count !== want.cnt)
                begin
                    $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
                    errors++;
                end
            end
        end
    end

    // Receiver: long hold on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((stall_phase % 4) < 2);
            endcase
        end
    end

    initial
    begin
        logic [OPC_W-1:0] op;
        logic [KEY_W-1:0] k;
        int               r;
        int               add_pct;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_capacity(CAP_RESET);
        foreach (DIR_ROWS[i])
            send_item(DIR_ROWS[i].op, DIR_ROWS[i].k, DIR_ROWS[i].d,
                      DIR_ROWS[i].typed, DIR_ROWS[i].res);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_capacity(PHASE_CAPS[ph]);
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
            for (int j = 4; j < POOL_N; j++)
                key_pool[j] = $urandom;
            add_pct = $urandom_range(35, 60);
            // flood the engine while the receiver holds off
            if (ph == 2)
            begin
                no_gaps = 1'b1;
                hold_requests++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < add_pct)
                    op = OP_ADD;
                else if (r < add_pct + 30)
                    op = OP_DEL;
                else if (r < 95)
                    op = OP_FIND;
                else
                    op = OP_SPARE;
                k = ($urandom_range(0, 9) == 0) ? $urandom
                                                : key_pool[$urandom_range(0, POOL_N-1)];
                send_item(op, k, $urandom, 1'b0, '0);
            end
            no_gaps = 1'b0;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
